>>> hdl/bfch_pkg.sv
package bfch_pkg;

  localparam int NUM_BANDS  = 16;
  localparam int RING_DEPTH = 2048;
  localparam int BAND_W     = $clog2(NUM_BANDS);
  localparam int SLOT_W     = $clog2(RING_DEPTH);
  localparam int DIGITS     = 8;

  // opcodes
  localparam logic [7:0] OP_SET  = 8'h01;
  localparam logic [7:0] OP_READ = 8'h03;

  // result kinds
  localparam logic KIND_DDS   = 1'b0;
  localparam logic KIND_REPLY = 1'b1;

  // fixed tail of a read reply
  localparam logic [7:0] REPLY_PAD = 8'h00;
  localparam logic [7:0] REPLY_LEN = 8'h06;

  // reply byte positions
  localparam logic [2:0] BYTE_PAD  = 3'd4;
  localparam logic [2:0] BYTE_LAST = 3'd5;

  typedef struct packed {
    logic [31:0] bcd_frequency;
    logic [7:0]  mode;
  } cmd_t;

  typedef struct packed {
    logic        kind;
    logic [30:0] dds_frequency;
    logic        save_request;
    logic [7:0]  reply_byte;
    logic [10:0] buffer_slot;
    logic        last;
  } result_t;

  // per-item control carried down the pipeline
  typedef struct packed {
    logic        valid;
    logic        is_set;
    logic [31:0] reply;
  } tag_t;

endpackage

>>> hdl/bfch_decode.sv
module bfch_decode import bfch_pkg::*; (
  input  logic [31:0] bcd,
  output logic [31:0] norm
);

  logic [3:0] count;
  logic       run;
  logic [5:0] sh;

  // count leading valid digits, then right-align them
  always_comb begin
    run   = 1'b1;
    count = '0;
    for (int k = DIGITS - 1; k >= 0; k--) begin
      if (bcd[4*k +: 4] > 4'd9) begin
        run = 1'b0;
      end
      if (run) begin
        count = count + 4'd1;
      end
    end
    sh   = 6'd32 - {count, 2'b00};
    norm = bcd >> sh;
  end

endmodule

>>> hdl/bfch_band_mem.sv
module bfch_band_mem import bfch_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic [BAND_W-1:0] rd_band,
  input  logic              wr_en,
  input  logic [BAND_W-1:0] wr_band,
  input  logic [31:0]       wr_data,
  output logic [31:0]       rd_data
);

  logic [31:0]          mem [NUM_BANDS];
  logic [NUM_BANDS-1:0] filled;
  logic [31:0]          mq;
  logic                 mvq;
  logic                 fwd_hit;
  logic [31:0]          fwd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_band] <= wr_data;
    end
    if (en) begin
      mq       <= mem[rd_band];
      fwd_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled  <= '0;
      mvq     <= 1'b0;
      fwd_hit <= 1'b0;
    end else begin
      if (wr_en) begin
        filled[wr_band] <= 1'b1;
      end
      if (en) begin
        mvq     <= filled[rd_band];
        // write in the same cycle as the read wins
        fwd_hit <= wr_en && (wr_band == rd_band);
      end
    end
  end

  assign rd_data = fwd_hit ? fwd_data : (mvq ? mq : '0);

endmodule

>>> hdl/bfch_convert.sv
module bfch_convert import bfch_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic [31:0] norm,
  input  tag_t        tag_in,
  output logic [26:0] value,
  output tag_t        tag_out
);

  logic [6:0]  pair [4];
  logic [6:0]  pair_q [4];
  logic [13:0] quad [2];
  logic [13:0] quad_q [2];
  logic [26:0] value_q;
  tag_t        t2;
  tag_t        t3;
  tag_t        t4;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      pair[j] = 7'(norm[8*j+4 +: 4]) * 7'd10 + 7'(norm[8*j +: 4]);
    end
    for (int m = 0; m < 2; m++) begin
      quad[m] = 14'(pair_q[2*m+1]) * 14'd100 + 14'(pair_q[2*m]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pair_q  <= pair;
      quad_q  <= quad;
      value_q <= 27'(quad_q[1]) * 27'd10000 + 27'(quad_q[0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t2 <= '0;
      t3 <= '0;
      t4 <= '0;
    end else if (en) begin
      t2 <= tag_in;
      t3 <= t2;
      t4 <= t3;
    end
  end

  assign value   = value_q;
  assign tag_out = t4;

endmodule

>>> hdl/bfch_serial.sv
module bfch_serial import bfch_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  tag_t        tag,
  input  logic [26:0] value,
  output logic        free,
  output logic        out_valid,
  input  logic        out_ready,
  output result_t     out_item
);

  logic              active;
  logic              is_set;
  logic [30:0]       dds;
  logic [31:0]       reply;
  logic [2:0]        cnt;
  logic [SLOT_W-1:0] wp;
  logic              take;
  logic              last;
  logic [7:0]        byte_sel;

  assign take = active && out_ready;
  assign last = is_set || (cnt == BYTE_LAST);
  assign free = !active || (out_ready && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      is_set <= 1'b0;
      cnt    <= '0;
      wp     <= '0;
    end else begin
      if (free) begin
        active <= tag.valid;
        is_set <= tag.is_set;
        cnt    <= '0;
      end else if (take) begin
        cnt <= cnt + 3'd1;
      end
      if (take && !is_set) begin
        wp <= (wp == SLOT_W'(RING_DEPTH - 1)) ? '0 : wp + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (free) begin
      dds   <= 31'(value) * 31'd20;
      reply <= tag.reply;
    end
  end

  always_comb begin
    unique case (cnt)
      3'd0:      byte_sel = reply[31:24];
      3'd1:      byte_sel = reply[23:16];
      3'd2:      byte_sel = reply[15:8];
      3'd3:      byte_sel = reply[7:0];
      BYTE_PAD:  byte_sel = REPLY_PAD;
      BYTE_LAST: byte_sel = REPLY_LEN;
      default:   byte_sel = '0;
    endcase
  end

  always_comb begin
    out_item.kind          = is_set ? KIND_DDS : KIND_REPLY;
    out_item.dds_frequency = is_set ? dds : '0;
    out_item.save_request  = is_set;
    out_item.reply_byte    = is_set ? '0 : byte_sel;
    out_item.buffer_slot   = is_set ? '0 : 11'(wp);
    out_item.last          = last;
  end

  assign out_valid = active;

endmodule

>>> hdl/bcd_frequency_command_handler.sv
// a command's first result is offered after stage 1, the converter stages and the
//   output serializer; a set gives one update, a read six reply bytes, and new
//   input waits for an item's last result to be taken; other opcodes give nothing
// reset (synchronous, active high): all band frequencies read as zero, ring
//   pointer and band_select go to zero, pipeline and output are emptied
module bcd_frequency_command_handler import bfch_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  cmd_t       in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output result_t    out_item,
  input  logic       cfg_write,
  input  logic [3:0] cfg_data
);

  logic [3:0]  band_select;
  logic        advance;
  logic        accept;
  logic [31:0] norm;

  // stage 1: decoded command, band memory read in flight
  logic        s1_valid;
  logic        s1_set;
  logic [3:0]  s1_band;
  logic [31:0] s1_norm;
  logic        s1_ok;

  logic        wr_en;
  logic [31:0] rd_data;
  tag_t        tag_s1;
  tag_t        tag_s4;
  logic [26:0] value_s4;

  // band select register; the user must write it only while idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      band_select <= '0;
    end else if (cfg_write) begin
      band_select <= cfg_data;
    end
  end

  // whole pipeline moves together whenever the serializer can take a new item
  assign in_ready = advance;
  assign accept   = in_valid && in_ready;

  // right-align the leading valid digits of the command
  bfch_decode u_decode (
    .bcd  (in_item.bcd_frequency),
    .norm (norm)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_set   <= 1'b0;
    end else if (advance) begin
      // unknown opcodes are accepted and dropped here
      s1_valid <= accept && ((in_item.mode == OP_SET) || (in_item.mode == OP_READ));
      s1_set   <= in_item.mode == OP_SET;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_band <= band_select;
      s1_norm <= norm;
    end
  end

  assign s1_ok = 32'(s1_band) < NUM_BANDS;

  // the memory keeps the normalized digits of each band; a read rebuilds the
  // reply straight from them, a set writes them back as it leaves stage 1
  assign wr_en = advance && s1_valid && s1_set && s1_ok;

  bfch_band_mem u_band_mem (
    .clk     (clk),
    .rst     (rst),
    .en      (advance),
    .rd_band (band_select[BAND_W-1:0]),
    .wr_en   (wr_en),
    .wr_band (s1_band[BAND_W-1:0]),
    .wr_data (s1_norm),
    .rd_data (rd_data)
  );

  // out-of-range band reads as zero
  always_comb begin
    tag_s1.valid  = s1_valid;
    tag_s1.is_set = s1_set;
    tag_s1.reply  = (s1_ok && !s1_set) ? rd_data : '0;
  end

  // decimal digits to binary over three stages
  bfch_convert u_convert (
    .clk     (clk),
    .rst     (rst),
    .en      (advance),
    .norm    (s1_norm),
    .tag_in  (tag_s1),
    .value   (value_s4),
    .tag_out (tag_s4)
  );

  // output register: one update or six reply bytes per item
  bfch_serial u_serial (
    .clk       (clk),
    .rst       (rst),
    .tag       (tag_s4),
    .value     (value_s4),
    .free      (advance),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

>>> dv/bcd_frequency_command_handler_tb.sv
`timescale 1ns / 1ps

module bcd_frequency_command_handler_tb;
  import bfch_pkg::*;

  // opcodes outside the command set, used to check that they are dropped
  localparam logic [7:0] OP_ZERO     = 8'h00;
  localparam logic [7:0] OP_TWO      = 8'h02;
  localparam logic [7:0] OP_SET_HIGH = 8'h81;
  localparam logic [7:0] OP_ONES     = 8'hFF;

  localparam int NUM_DIR         = 24;
  localparam int NUM_PHASES      = 6;
  localparam int ITEMS_PER_PHASE = 76;
  localparam int SETTLE_CYCLES   = 12;    // lets an ignored opcode clear the pipeline
  localparam int TAIL_CYCLES     = 20;
  localparam int HOLD_CYCLES     = 200;   // long receiver hold-off
  localparam int STALL_LIMIT     = 2000;  // cycles with no item moving on either side
  localparam int MAX_REPORTS     = 10;

  // one directed row: band to select, command, and optionally a hand-written
  // expectation (dds word for a set, packed reply digits for a read)
  typedef struct packed {
    logic [3:0]  band;
    logic [7:0]  mode;
    logic [31:0] bcd;
    logic        pinned;
    logic [31:0] pinned_val;
  } dir_row_t;

  logic    clk;
  logic    rst;
  logic    in_valid;
  logic    in_ready;
  cmd_t    in_item;
  logic    out_valid;
  logic    out_ready;
  result_t out_item;
  logic    cfg_write;
  logic [3:0] cfg_data;

  // reference state of the handler
  logic [29:0] band_freq_model [NUM_BANDS];
  int          ring_ptr_model;
  logic [3:0]  band_sel_model;

  result_t expected_results [$];

  int  mismatch_cnt;
  int  set_cnt;
  int  read_cnt;
  int  ignored_cnt;
  int  result_cnt;
  int  wrap_cnt;
  int  cfg_cnt;
  int  stall_cycles;
  bit  src_idle;
  bit  sink_idle;
  bit  long_hold;

  dir_row_t dir_table [NUM_DIR] = '{
    // after reset every band reads as zero
    '{4'd0,  OP_READ,     32'h0000_0000, 1'b1, 32'h0000_0000},
    // largest legal frequency, then read it back
    '{4'd0,  OP_SET,      32'h9999_9999, 1'b1, 32'd1999999980},
    '{4'd0,  OP_READ,     32'h0000_0000, 1'b1, 32'h9999_9999},
    '{4'd0,  OP_SET,      32'h0000_0000, 1'b1, 32'd0},
    '{4'd0,  OP_READ,     32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
    // no valid leading digit gives zero
    '{4'd0,  OP_SET,      32'hFFFF_FFFF, 1'b1, 32'd0},
    '{4'd0,  OP_SET,      32'hA000_0000, 1'b1, 32'd0},
    // digits stop at the first bad nibble
    '{4'd0,  OP_SET,      32'h12A4_5678, 1'b1, 32'd240},
    '{4'd0,  OP_READ,     32'h0000_0000, 1'b1, 32'h0000_0012},
    // top band is independent of band 0
    '{4'd15, OP_SET,      32'h8765_4321, 1'b1, 32'd1753086420},
    '{4'd15, OP_READ,     32'h0000_0000, 1'b1, 32'h8765_4321},
    // unknown opcodes leave everything alone
    '{4'd15, OP_ZERO,     32'h1234_5678, 1'b0, 32'd0},
    '{4'd15, OP_ONES,     32'hFFFF_FFFF, 1'b0, 32'd0},
    '{4'd15, OP_TWO,      32'h0000_0001, 1'b0, 32'd0},
    '{4'd15, OP_SET_HIGH, 32'h5555_5555, 1'b0, 32'd0},
    '{4'd15, OP_READ,     32'hAAAA_AAAA, 1'b1, 32'h8765_4321},
    '{4'd0,  OP_READ,     32'h0000_0000, 1'b1, 32'h0000_0012},
    '{4'd7,  OP_SET,      32'h9FFF_FFFF, 1'b1, 32'd180},
    '{4'd7,  OP_READ,     32'h0000_0000, 1'b1, 32'h0000_0009},
    '{4'd7,  OP_SET,      32'h0000_0001, 1'b1, 32'd20},
    '{4'd7,  OP_READ,     32'h0000_0000, 1'b1, 32'h0000_0001},
    // remaining rows go through the predictor only
    '{4'd7,  OP_SET,      32'h5A5A_5A5A, 1'b0, 32'd0},
    '{4'd7,  OP_SET,      32'h0123_456F, 1'b0, 32'd0},
    '{4'd7,  OP_READ,     32'h0000_0000, 1'b0, 32'd0}
  };

  bcd_frequency_command_handler u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // decimal value of the leading bcd digits, top nibble first
  function automatic int unsigned leading_digits(logic [31:0] bcd);
    int unsigned acc;
    bit          stop;
    logic [3:0]  nib;
    acc = 0;
    stop = 1'b0;
    for (int k = 7; k >= 0; k--) begin
      nib = bcd[4*k +: 4];
      if (nib > 4'd9) stop = 1'b1;
      if (!stop) acc = acc * 10 + nib;
    end
    return acc;
  endfunction

  // work out the results of one accepted command and queue them
  task automatic predict_command(input cmd_t c, input bit pinned,
                                 input logic [31:0] pinned_val);
    result_t     r;
    logic [29:0] hz;
    logic [31:0] word;
    int unsigned v;
    if (c.mode == OP_SET) begin
      hz = 30'(leading_digits(c.bcd_frequency) * 10);
      if (band_sel_model < NUM_BANDS) band_freq_model[band_sel_model] = hz;
      r = '0;
      r.kind          = KIND_DDS;
      r.dds_frequency = pinned ? pinned_val[30:0] : {hz, 1'b0};
      r.save_request  = 1'b1;
      r.last          = 1'b1;
      expected_results.push_back(r);
      set_cnt++;
    end else if (c.mode == OP_READ) begin
      v = (band_sel_model < NUM_BANDS) ? band_freq_model[band_sel_model] / 10 : 0;
      for (int k = 0; k < DIGITS; k++) begin
        word[4*k +: 4] = 4'(v % 10);
        v = v / 10;
      end
      if (pinned) word = pinned_val;
      for (int k = 0; k < 6; k++) begin
        r = '0;
        r.kind        = KIND_REPLY;
        r.buffer_slot = 11'(ring_ptr_model);
        r.last        = (k == BYTE_LAST);
        if (k < BYTE_PAD) r.reply_byte = word[31 - 8*k -: 8];
        else if (k == BYTE_PAD) r.reply_byte = REPLY_PAD;
        else r.reply_byte = REPLY_LEN;
        expected_results.push_back(r);
        // ring pointer wraps at the ring depth
        if (ring_ptr_model == RING_DEPTH - 1) begin
          ring_ptr_model = 0;
          wrap_cnt++;
        end else begin
          ring_ptr_model++;
        end
      end
      read_cnt++;
    end else begin
      ignored_cnt++;
    end
  endtask

  // random command: mostly reads and sets, some noise opcodes
  function automatic cmd_t random_command();
    cmd_t        c;
    int unsigned pick;
    int unsigned shape;
    int unsigned pos;
    pick  = $urandom_range(0, 99);
    shape = $urandom_range(0, 9);
    pos   = $urandom_range(0, 7);
    c.mode = (pick < 75) ? OP_READ : (pick < 95) ? OP_SET : 8'($urandom);
    for (int k = 0; k < DIGITS; k++) c.bcd_frequency[4*k +: 4] = 4'($urandom_range(0, 9));
    // a bad nibble somewhere cuts the digit string short
    if (shape >= 7) c.bcd_frequency[4*pos +: 4] = 4'($urandom_range(10, 15));
    if (shape == 9 || c.mode != OP_SET) c.bcd_frequency = $urandom;
    return c;
  endfunction

  // offer one command and hold it until the handler takes it
  task automatic send_cmd(input cmd_t c, input bit pinned, input logic [31:0] pinned_val);
    int n;
    if (src_idle && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= c;
    do @(posedge clk); while (!in_ready);
    predict_command(c, pinned, pinned_val);
  endtask

  // stop sending and wait for every queued result to come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // band select changes only once the handler has gone quiet; an ignored
  // opcode may still be in flight after the last result, hence the extra wait
  task automatic set_band(input logic [3:0] band);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= band;
    band_sel_model = band;
    cfg_cnt++;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // result side: ready with random hold-off bursts, and one long hold on request
  initial begin : result_sink
    int n;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
        out_ready <= 1'b1;
      end else if (sink_idle && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 6);
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin : result_check
    result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      result_cnt++;
      if (expected_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("[%0t] unexpected result: kind=%0d dds=%0d save=%0d byte=%02h slot=%0d last=%0d",
                   $realtime, out_item.kind, out_item.dds_frequency, out_item.save_request,
                   out_item.reply_byte, out_item.buffer_slot, out_item.last);
      end else begin
        exp_r = expected_results.pop_front();
        if (out_item.kind !== exp_r.kind || out_item.dds_frequency !== exp_r.dds_frequency ||
            out_item.save_request !== exp_r.save_request ||
            out_item.reply_byte !== exp_r.reply_byte ||
            out_item.buffer_slot !== exp_r.buffer_slot || out_item.last !== exp_r.last) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS) begin
            $display("[%0t] mismatch: expected kind=%0d dds=%0d save=%0d byte=%02h slot=%0d last=%0d",
                     $realtime, exp_r.kind, exp_r.dds_frequency, exp_r.save_request,
                     exp_r.reply_byte, exp_r.buffer_slot, exp_r.last);
            $display("[%0t]           actual kind=%0d dds=%0d save=%0d byte=%02h slot=%0d last=%0d",
                     $realtime, out_item.kind, out_item.dds_frequency, out_item.save_request,
                     out_item.reply_byte, out_item.buffer_slot, out_item.last);
          end
        end
      end
    end
  end

  // watchdog on cycles where no item moves on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles, %0d results still expected",
               STALL_LIMIT, expected_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int n;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_item   <= '0;
    cfg_write <= 1'b0;
    cfg_data  <= '0;
    for (int b = 0; b < NUM_BANDS; b++) band_freq_model[b] = '0;
    ring_ptr_model = 0;
    band_sel_model = '0;
    mismatch_cnt = 0;
    set_cnt      = 0;
    read_cnt     = 0;
    ignored_cnt  = 0;
    result_cnt   = 0;
    wrap_cnt     = 0;
    cfg_cnt      = 0;
    stall_cycles = 0;
    src_idle     = 1'b1;
    sink_idle    = 1'b1;
    long_hold    = 1'b0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed table; band select is rewritten whenever a row changes it
    for (int i = 0; i < NUM_DIR; i++) begin
      if (i == 0 || dir_table[i].band != band_sel_model) set_band(dir_table[i].band);
      send_cmd(cmd_t'{bcd_frequency: dir_table[i].bcd, mode: dir_table[i].mode},
               dir_table[i].pinned, dir_table[i].pinned_val);
    end

    // random phases, each selecting a band; extreme bands come first
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_band((p == 0) ? 4'd0 : (p == 1) ? 4'd15 : 4'($urandom_range(0, 15)));
      src_idle  = (p != 3) && (p != NUM_PHASES - 1);
      sink_idle = (p != 3) && (p != NUM_PHASES - 1);
      // receiver stalls long enough for the handler to back up its input
      if (p == 2) long_hold = 1'b1;
      n = 0;
      // the last phase keeps going until the reply ring has wrapped
      while (n < ITEMS_PER_PHASE || (p == NUM_PHASES - 1 && wrap_cnt == 0)) begin
        // sender pauses mid-phase until the handler is empty
        if (p == 4 && n == ITEMS_PER_PHASE / 2) drain();
        send_cmd(random_command(), 1'b0, 32'd0);
        n++;
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d sets, %0d reads, %0d ignored commands over %0d band writes",
             set_cnt, read_cnt, ignored_cnt, cfg_cnt);
    $display("checked %0d results, reply ring wrapped %0d time(s), %0d mismatches",
             result_cnt, wrap_cnt, mismatch_cnt);
    if (mismatch_cnt == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/bfch_pkg.sv
hdl/bfch_decode.sv
hdl/bfch_band_mem.sv
hdl/bfch_convert.sv
hdl/bfch_serial.sv
hdl/bcd_frequency_command_handler.sv
dv/bcd_frequency_command_handler_tb.sv
